[design/campu_pkg.sv]
// Package for the camera port pixel unpacker.
// Shared types, register indexes, packing phases and pixel scaling functions.
// No dependencies.
`timescale 1ns / 1ps

package campu_pkg;

    localparam int PIXEL_W   = 8;
    localparam int MAX_RUN   = 6;
    localparam int RUN_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int COUNT_W   = 9;
    localparam int XFER_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIX_BIT       = 2'd0,
        CFG_BIDIR         = 2'd1,
        CFG_PIX_PER_LINE  = 2'd2,
        CFG_XFER_PER_LINE = 2'd3
    } cfg_index_t;

    // Nibble-mode 6-bit packer phases; the unused code behaves as PHASE_LEAD.
    localparam logic [1:0] PHASE_LEAD = 2'd0;
    localparam logic [1:0] PHASE_MID  = 2'd1;
    localparam logic [1:0] PHASE_TAIL = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_SAT    = 9'd511;
    localparam logic [COUNT_W-1:0] PPL_RESET    = 9'd160;
    localparam logic [XFER_W-1:0]  XFER_RESET   = 8'd80;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef pixel_t [MAX_RUN-1:0] pixel_run_t;

    typedef struct packed {
        pixel_run_t       pixels;
        logic [RUN_W-1:0] count;
        logic [1:0]       phase;
        logic [5:0]       carried;
    } unpack_t;

    typedef struct packed {
        logic             load;
        logic [RUN_W-1:0] kept;
        logic             line_done;
    } run_ctrl_t;

    // 4-bit pixel: (16 - v) mod 16, scaled to 8 bits
    function automatic pixel_t scale4(input logic [3:0] v);
        logic [3:0] neg;
        neg = 4'd0 - v;
        return {neg, 4'b0000};
    endfunction

    // 6-bit pixel: 63 - v, scaled to 8 bits
    function automatic pixel_t scale6(input logic [5:0] v);
        return {~v, 2'b00};
    endfunction

endpackage

[design/campu_unpack.sv]
// Pixel unpacker: splits one transfer into up to six scaled gray pixels.
// Also computes the next nibble-mode packer phase and carried bits.
// Depends on campu_pkg.
`timescale 1ns / 1ps

module campu_unpack (
    input  logic [7:0]        first_data,
    input  logic [7:0]        first_status,
    input  logic [7:0]        second_data,
    input  logic [7:0]        second_status,
    input  logic              six_bit,
    input  logic              bidir,
    input  logic [1:0]        phase,
    input  logic [5:0]        carried,
    output campu_pkg::unpack_t res
);
    import campu_pkg::*;

    logic [3:0] lo_nib;
    logic [3:0] hi_nib;

    assign lo_nib = first_status[7:4];
    assign hi_nib = second_status[7:4];

    always_comb
    begin
        res.pixels  = '0;
        res.count   = '0;
        res.phase   = phase;
        res.carried = carried;
        if (bidir)
        begin
            if (!six_bit)
            begin
                res.pixels[0] = scale4(first_data[4:1]);
                res.pixels[1] = scale4({first_status[3], first_data[7:5]});
                res.pixels[2] = scale4(first_status[7:4]);
                res.pixels[3] = scale4(second_data[4:1]);
                res.pixels[4] = scale4({second_status[3], second_data[7:5]});
                res.pixels[5] = scale4(second_status[7:4]);
                res.count     = 3'd6;
            end
            else
            begin
                res.pixels[0] = scale6(first_data[6:1]);
                res.pixels[1] = scale6({first_status[7:3], first_data[7]});
                res.pixels[2] = scale6(second_data[6:1]);
                res.pixels[3] = scale6({second_status[7:3], second_data[7]});
                res.count     = 3'd4;
            end
        end
        else if (!six_bit)
        begin
            res.pixels[0] = scale4(lo_nib);
            res.pixels[1] = scale4(hi_nib);
            res.count     = 3'd2;
        end
        else
        begin
            case (phase)
                PHASE_MID:
                begin
                    res.pixels[0] = scale6(carried | {2'b00, lo_nib});
                    res.carried   = {hi_nib, 2'b00};
                    res.phase     = PHASE_TAIL;
                    res.count     = 3'd1;
                end
                PHASE_TAIL:
                begin
                    res.pixels[0] = scale6(carried | {4'b0000, lo_nib[3:2]});
                    res.pixels[1] = scale6({lo_nib[1:0], hi_nib});
                    res.phase     = PHASE_LEAD;
                    res.count     = 3'd2;
                end
                default:
                begin
                    res.pixels[0] = scale6({lo_nib, hi_nib[3:2]});
                    res.carried   = {hi_nib[1:0], 4'b0000};
                    res.phase     = PHASE_MID;
                    res.count     = 3'd1;
                end
            endcase
        end
    end

endmodule

[design/campu_result_buf.sv]
// Result buffer: holds the kept pixels of one transfer and sends them one per cycle while out_stall is low.
// Frees itself in the cycle the last pixel leaves so the next run loads at once.
// Depends on campu_pkg.
`timescale 1ns / 1ps

module campu_result_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  campu_pkg::run_ctrl_t  ctrl,
    input  campu_pkg::pixel_run_t pixels,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pixel_value,
    output logic                  last_of_run,
    output logic                  line_done
);
    import campu_pkg::*;

    pixel_run_t       pix_reg;
    logic             done_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [RUN_W-1:0] cnt_reg;
    logic [RUN_W-1:0] idx_reg;
    logic [RUN_W-1:0] idx_next;
    logic             take;
    logic             last;

    assign take = busy_reg && !out_stall;
    assign last = (idx_reg == cnt_reg - 3'd1);
    assign free = !busy_reg || (take && last);

    assign out_valid   = busy_reg;
    assign pixel_value = pix_reg[idx_reg];
    assign last_of_run = last;
    assign line_done   = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (ctrl.load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (ctrl.load)
                cnt_reg <= ctrl.kept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pix_reg  <= pixels;
            done_reg <= ctrl.line_done;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cnt_reg))
        else $error("result index past run length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> (free && ctrl.kept != 3'd0))
        else $error("run loaded over pending results or empty");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last && !ctrl.load) |=> (busy_reg && idx_reg == $past(idx_reg) + 3'd1))
        else $error("result index did not advance");
`endif

endmodule

[design/camera_port_pixel_unpacker.sv]
// Top level of the camera port pixel unpacker.
// Holds configuration, the input register and line state; uses campu_unpack and
// campu_result_buf. Depends on campu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one port transfer: two data and
//   status byte pairs. Output channel (out_valid / out_stall) carries one pixel
//   per transaction, with last_of_run on the final pixel of a transfer and
//   line_done on every pixel of a transfer that closes a line.
//   Configuration is written through cfg_write / cfg_index / cfg_data; the user
//   must write it only while idle, as the block itself does not enforce this.
//   A transfer is captured in the input register, then loaded into the result
//   buffer once it is free, from which its first pixel is valid. The buffer sends
//   one pixel per cycle while out_stall is low, at most six per transfer; a
//   transfer whose pixels are all dropped skips the buffer and gives no output.
//   The input register takes the next transfer while the buffer still drains.
//   Reset: config returns to 4-bit, nibble mode, 160 pixels, 80 transfers per
//   line; packer phase, carried bits and line counters clear; both channels
//   empty. When out_stall is high the current pixel holds, the buffer holds, and
//   once the input register holds a transfer with kept pixels in_stall rises.
`timescale 1ns / 1ps

module camera_port_pixel_unpacker #(
    parameter int MAX_LINE_PIXELS = 320
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [campu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [campu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      first_data,
    input  logic [7:0]                      first_status,
    input  logic [7:0]                      second_data,
    input  logic [7:0]                      second_status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      pixel_value,
    output logic                            last_of_run,
    output logic                            line_done
);
    import campu_pkg::*;

    localparam int LimCap = (MAX_LINE_PIXELS > 511) ? 511 : MAX_LINE_PIXELS;
    localparam logic [COUNT_W-1:0] LIM_CAP = COUNT_W'(LimCap);

    // configuration
    logic               six_bit_reg;
    logic               bidir_reg;
    logic [COUNT_W-1:0] ppl_reg;
    logic [XFER_W-1:0]  xpl_reg;

    // input register
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] d1_reg;
    logic [7:0] s1_reg;
    logic [7:0] d2_reg;
    logic [7:0] s2_reg;

    // line state
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [5:0]         carried_reg;
    logic [5:0]         carried_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [XFER_W-1:0]  xfer_reg;
    logic [XFER_W-1:0]  xfer_next;

    unpack_t            unp;
    run_ctrl_t          ctrl;
    logic               buf_free;
    logic               consume;
    logic               in_take;
    logic [XFER_W-1:0]  xfer_inc;
    logic               done;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] room;
    logic [RUN_W-1:0]   kept;
    logic [COUNT_W:0]   total;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            six_bit_reg <= 1'b0;
            bidir_reg   <= 1'b0;
            ppl_reg     <= PPL_RESET;
            xpl_reg     <= XFER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SIX_BIT:       six_bit_reg <= cfg_data[0];
                CFG_BIDIR:         bidir_reg   <= cfg_data[0];
                CFG_PIX_PER_LINE:  ppl_reg     <= cfg_data[COUNT_W-1:0];
                CFG_XFER_PER_LINE: xpl_reg     <= cfg_data[XFER_W-1:0];
                default:           ;
            endcase
        end
    end

    campu_unpack u_unpack (
        .first_data    (d1_reg),
        .first_status  (s1_reg),
        .second_data   (d2_reg),
        .second_status (s2_reg),
        .six_bit       (six_bit_reg),
        .bidir         (bidir_reg),
        .phase         (phase_reg),
        .carried       (carried_reg),
        .res           (unp)
    );

    // keep only the pixels that still fit in the line; they form a prefix
    always_comb
    begin
        limit = (ppl_reg > LIM_CAP) ? LIM_CAP : ppl_reg;
        room  = (limit > count_reg) ? (limit - count_reg) : '0;
        kept  = (room < {{(COUNT_W-RUN_W){1'b0}}, unp.count}) ? room[RUN_W-1:0] : unp.count;
    end

    assign xfer_inc = xfer_reg + 8'd1;
    assign done     = (xfer_inc >= xpl_reg);
    assign total    = {1'b0, count_reg} + {{(COUNT_W+1-RUN_W){1'b0}}, unp.count};

    // a transfer with nothing kept moves on without waiting for the buffer
    assign consume  = in_full_reg && ((kept == '0) || buf_free);
    assign in_stall = in_full_reg && !consume;
    assign in_take  = in_valid && !in_stall;

    assign ctrl.load      = consume && (kept != '0);
    assign ctrl.kept      = kept;
    assign ctrl.line_done = done;

    always_comb
    begin
        in_full_next = in_take || (in_full_reg && !consume);
        phase_next   = phase_reg;
        carried_next = carried_reg;
        count_next   = count_reg;
        xfer_next    = xfer_reg;
        if (consume)
        begin
            if (done)
            begin
                phase_next   = PHASE_LEAD;
                carried_next = '0;
                count_next   = '0;
                xfer_next    = '0;
            end
            else
            begin
                phase_next   = unp.phase;
                carried_next = unp.carried;
                count_next   = total[COUNT_W] ? COUNT_SAT : total[COUNT_W-1:0];
                xfer_next    = xfer_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            phase_reg   <= PHASE_LEAD;
            carried_reg <= '0;
            count_reg   <= '0;
            xfer_reg    <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            phase_reg   <= phase_next;
            carried_reg <= carried_next;
            count_reg   <= count_next;
            xfer_reg    <= xfer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            d1_reg <= first_data;
            s1_reg <= first_status;
            d2_reg <= second_data;
            s2_reg <= second_status;
        end
    end

    campu_result_buf u_result_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .pixels      (unp.pixels),
        .free        (buf_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_value (pixel_value),
        .last_of_run (last_of_run),
        .line_done   (line_done)
    );

endmodule
